// ----- design/b58_pkg.sv -----
// Shared constants, types and helpers for the base58 encoder.
package b58_pkg;

  localparam int MAX_BYTES_DEF = 32;
  localparam int RADIX = 58;
  localparam int RECIP_SHIFT = 16;
  localparam logic [10:0] RECIP58 = 11'd1130;
  localparam logic [7:0] CHAR_ONE = 8'h31;

  localparam logic [7:0] ALPHABET [RADIX] = '{
    "1", "2", "3", "4", "5", "6", "7", "8", "9",
    "A", "B", "C", "D", "E", "F", "G", "H", "J", "K", "L", "M", "N", "P", "Q", "R",
    "S", "T", "U", "V", "W", "X", "Y", "Z",
    "a", "b", "c", "d", "e", "f", "g", "h", "i", "j", "k", "m", "n", "o", "p", "q",
    "r", "s", "t", "u", "v", "w", "x", "y", "z"
  };

  typedef struct packed {
    logic in_ready;
    logic take;
    logic div_begin;
    logic pass_init;
    logic pass_step;
    logic emit_rd;
    logic emit_ld;
  } b58_cmd_t;

  typedef struct packed {
    logic n_left;
    logic pass_end;
    logic more;
    logic out_free;
    logic emit_last;
  } b58_sts_t;

  function automatic logic [7:0] b58_char(input logic [5:0] digit);
    logic [7:0] ch;
    ch = (digit < 6'(RADIX)) ? ALPHABET[digit] : ALPHABET[0];
    return ch;
  endfunction

endpackage

// ----- design/b58_if.sv -----
// Request channel interfaces for message bytes in and encoded characters out.
interface b58_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b58_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  logic       overflow;

  modport source (output valid, output char_code, output last_char, output overflow,
                  input ready);
  modport sink (input valid, input char_code, input last_char, input overflow,
                output ready);
endinterface

// ----- design/b58_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module b58_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                        wr_data_i,
  input  logic                                    rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                        rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/b58_ctrl.sv -----
// Sequencer for collect, repeated division by 58 and character emission.
module b58_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  input  b58_pkg::b58_sts_t  sts_i,
  output b58_pkg::b58_cmd_t  cmd_o
);
  import b58_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_ERD   = 3'd4;
  localparam logic [2:0] S_ELD   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (in_last_i) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd_o.div_begin = 1'b1;
        state_d = sts_i.n_left ? S_INIT : S_ERD;
      end
      S_INIT: begin
        cmd_o.pass_init = 1'b1;
        state_d = S_RUN;
      end
      S_RUN: begin
        cmd_o.pass_step = 1'b1;
        if (sts_i.pass_end) begin
          state_d = sts_i.more ? S_INIT : S_ERD;
        end
      end
      S_ERD: begin
        cmd_o.emit_rd = 1'b1;
        state_d = S_ELD;
      end
      S_ELD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          state_d = sts_i.emit_last ? S_IDLE : S_ERD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/b58_dp.sv -----
// Byte and digit stores, divide-by-58 step, counters and output register.
module b58_dp #(
  parameter int MAX_BYTES = b58_pkg::MAX_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  b58_pkg::b58_cmd_t  cmd_i,
  output b58_pkg::b58_sts_t  sts_o,
  input  logic [7:0]         data_byte_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [7:0]         char_code_o,
  output logic               last_char_o,
  output logic               overflow_o
);
  import b58_pkg::*;

  localparam int MAX_DIGITS = (MAX_BYTES * 138) / 100 + 1;
  localparam int BC_W = $clog2(MAX_BYTES + 1);
  localparam int BA_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int DC_W = $clog2(MAX_DIGITS + 1);
  localparam int DA_W = $clog2(MAX_DIGITS);

  logic [BC_W-1:0] byte_count_q, byte_count_d;
  logic [BC_W-1:0] zpc_q, zpc_d;
  logic [BC_W-1:0] start_q, start_d;
  logic [BC_W-1:0] idx_q, idx_d;
  logic [BC_W-1:0] nstart_q, nstart_d;
  logic [DC_W-1:0] dig_cnt_q, dig_cnt_d;
  logic [5:0]      rem_q, rem_d;
  logic            seen_q, seen_d;
  logic            ovf_q, ovf_d;
  logic            nz_q, nz_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      char_q;
  logic            last_q;
  logic            ovf_out_q;

  logic            full;
  logic [BC_W-1:0] idx_inc;
  logic            pass_end;
  logic [7:0]      work_byte;
  logic [13:0]     num;
  logic [24:0]     prod;
  logic [7:0]      quo;
  logic [13:0]     quo58;
  logic [13:0]     rmd_full;
  logic [5:0]      rmd;
  logic [BC_W-1:0] new_start;
  logic            emit_last;
  logic [DC_W-1:0] dig_dec;
  logic [5:0]      dig_rd;
  logic [7:0]      emit_char;

  logic            bram_wr_en;
  logic [BA_W-1:0] bram_wr_addr;
  logic [7:0]      bram_wr_data;
  logic            bram_rd_en;
  logic [BA_W-1:0] bram_rd_addr;
  logic            dram_wr_en;
  logic            dram_rd_en;

  assign full     = (byte_count_q == BC_W'(MAX_BYTES));
  assign idx_inc  = idx_q + 1'b1;
  assign pass_end = (idx_inc == byte_count_q);

  assign num      = {rem_q, work_byte};
  assign prod     = 25'(num) * 25'(RECIP58);
  assign quo      = prod[RECIP_SHIFT +: 8];
  assign quo58    = ({6'b0, quo} << 6) - ({6'b0, quo} << 2) - ({6'b0, quo} << 1);
  assign rmd_full = num - quo58;
  assign rmd      = rmd_full[5:0];

  assign new_start = nz_q ? nstart_q : ((quo != 8'd0) ? idx_q : byte_count_q);

  assign emit_last = (zpc_q != '0) ? ((zpc_q == BC_W'(1)) && (dig_cnt_q == '0))
                                   : (dig_cnt_q == DC_W'(1));
  assign dig_dec   = dig_cnt_q - 1'b1;
  assign emit_char = (zpc_q != '0) ? CHAR_ONE : b58_char(dig_rd);

  assign sts_o.n_left    = (zpc_q < byte_count_q);
  assign sts_o.pass_end  = pass_end;
  assign sts_o.more      = (new_start < byte_count_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.emit_last = emit_last;

  assign bram_wr_en   = (cmd_i.take && !full) || cmd_i.pass_step;
  assign bram_wr_addr = cmd_i.pass_step ? idx_q[BA_W-1:0] : byte_count_q[BA_W-1:0];
  assign bram_wr_data = cmd_i.pass_step ? quo : data_byte_i;
  assign bram_rd_en   = cmd_i.pass_init || (cmd_i.pass_step && !pass_end);
  assign bram_rd_addr = cmd_i.pass_init ? start_q[BA_W-1:0] : idx_inc[BA_W-1:0];

  assign dram_wr_en = cmd_i.pass_step && pass_end && (dig_cnt_q < DC_W'(MAX_DIGITS));
  assign dram_rd_en = cmd_i.emit_rd && (zpc_q == '0);

  b58_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_byte_ram (
    .clk_i     (clk_i),
    .wr_en_i   (bram_wr_en),
    .wr_addr_i (bram_wr_addr),
    .wr_data_i (bram_wr_data),
    .rd_en_i   (bram_rd_en),
    .rd_addr_i (bram_rd_addr),
    .rd_data_o (work_byte)
  );

  b58_ram #(
    .WIDTH (6),
    .DEPTH (MAX_DIGITS)
  ) u_digit_ram (
    .clk_i     (clk_i),
    .wr_en_i   (dram_wr_en),
    .wr_addr_i (dig_cnt_q[DA_W-1:0]),
    .wr_data_i (rmd),
    .rd_en_i   (dram_rd_en),
    .rd_addr_i (dig_dec[DA_W-1:0]),
    .rd_data_o (dig_rd)
  );

  always_comb begin
    byte_count_d = byte_count_q;
    zpc_d        = zpc_q;
    seen_d       = seen_q;
    ovf_d        = ovf_q;
    dig_cnt_d    = dig_cnt_q;
    start_d      = start_q;
    idx_d        = idx_q;
    nstart_d     = nstart_q;
    rem_d        = rem_q;
    nz_d         = nz_q;
    out_valid_d  = out_valid_q;

    if (cmd_i.take) begin
      if (!full) begin
        byte_count_d = byte_count_q + 1'b1;
        if (!seen_q) begin
          if (data_byte_i == 8'd0) begin
            zpc_d = zpc_q + 1'b1;
          end else begin
            seen_d = 1'b1;
          end
        end
      end else begin
        ovf_d = 1'b1;
      end
    end

    if (cmd_i.div_begin) begin
      start_d = zpc_q;
    end

    if (cmd_i.pass_init) begin
      idx_d    = start_q;
      rem_d    = '0;
      nz_d     = 1'b0;
      nstart_d = byte_count_q;
    end

    if (cmd_i.pass_step) begin
      rem_d = rmd;
      idx_d = idx_inc;
      if (!nz_q && (quo != 8'd0)) begin
        nz_d     = 1'b1;
        nstart_d = idx_q;
      end
      if (pass_end) begin
        start_d = new_start;
        if (dig_cnt_q < DC_W'(MAX_DIGITS)) begin
          dig_cnt_d = dig_cnt_q + 1'b1;
        end
      end
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.emit_ld) begin
      out_valid_d = 1'b1;
      if (zpc_q != '0) begin
        zpc_d = zpc_q - 1'b1;
      end else begin
        dig_cnt_d = dig_dec;
      end
      if (emit_last) begin
        byte_count_d = '0;
        zpc_d        = '0;
        seen_d       = 1'b0;
        ovf_d        = 1'b0;
        dig_cnt_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      zpc_q        <= '0;
      seen_q       <= 1'b0;
      ovf_q        <= 1'b0;
      dig_cnt_q    <= '0;
      nz_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      byte_count_q <= byte_count_d;
      zpc_q        <= zpc_d;
      seen_q       <= seen_d;
      ovf_q        <= ovf_d;
      dig_cnt_q    <= dig_cnt_d;
      nz_q         <= nz_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q  <= start_d;
    idx_q    <= idx_d;
    nstart_q <= nstart_d;
    rem_q    <= rem_d;
    if (cmd_i.emit_ld) begin
      char_q    <= emit_char;
      last_q    <= emit_last;
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;
  assign overflow_o  = ovf_out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= BC_W'(MAX_BYTES))
    else $error("byte count beyond capacity");

  a_prefix_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zpc_q <= byte_count_q)
    else $error("zero prefix longer than message");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pass_step |-> (idx_q < byte_count_q))
    else $error("division step outside stored bytes");

  a_clear_after_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_ld && emit_last) |=> (byte_count_q == '0) && (dig_cnt_q == '0) && !ovf_q)
    else $error("message state not cleared after final character");

endmodule

// ----- design/base58_encoder.sv -----
// Base58 encoder top level: byte message in, base58 character text out.
// Bytes arrive one per request, most significant first, and are taken one per cycle
// while the encoder is idle; up to MAX_BYTES are stored and later ones are dropped
// with the overflow flag set on the whole text. After the byte marked last, the number
// is divided by 58 again and again in a single byte-wide divide unit that walks the
// byte store, one stored byte per cycle with a setup state before each pass, starting
// each pass at the first nonzero quotient byte. Characters then leave one at a time,
// each read from the digit store and loaded into the output register once it is free,
// leading zero bytes as '1'; the next message may start as soon as the final
// character sits in that register.
module base58_encoder #(
  parameter int MAX_BYTES = b58_pkg::MAX_BYTES_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  b58_in_if.sink   in_i,
  b58_out_if.source out_o
);
  import b58_pkg::*;

  b58_cmd_t cmd;
  b58_sts_t sts;

  b58_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_byte),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  b58_dp #(
    .MAX_BYTES (MAX_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .data_byte_i (in_i.data_byte),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .char_code_o (out_o.char_code),
    .last_char_o (out_o.last_char),
    .overflow_o  (out_o.overflow)
  );

  assign in_i.ready = cmd.in_ready;

endmodule
